// ===== rtl/core/fm2op_pkg.sv =====
// fm2op_pkg: shared types, register codes and the sine table builder
// for the two-operator fm voice; no dependencies
package fm2op_pkg;

  localparam int CHANNELS        = 8;
  localparam int CH_W            = $clog2(CHANNELS);
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int ROM_AW          = $clog2(SINE_TABLE_SIZE);
  localparam int RAMP_SHIFT      = 9;

  localparam logic [2:0] REG_RATIO = 3'd0;
  localparam logic [2:0] REG_DETUNE = 3'd1;
  localparam logic [2:0] REG_I11 = 3'd2;
  localparam logic [2:0] REG_I12 = 3'd3;
  localparam logic [2:0] REG_I21 = 3'd4;
  localparam logic [2:0] REG_I22 = 3'd5;
  localparam logic [2:0] REG_VOLUME = 3'd6;
  localparam logic [2:0] REG_PAN = 3'd7;

  localparam logic [31:0] RATIO_RST  = 32'h0100_0100;
  localparam logic [31:0] VOLUME_RST = 32'h8000_8000;
  localparam logic [15:0] UNITY      = 16'h8000;
  localparam logic [15:0] CENTRE     = 16'h4000;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_SIZE];

  typedef struct packed {
    logic [31:0]        phase1;
    logic [31:0]        phase2;
    logic signed [23:0] fb1_last;
    logic signed [23:0] fb1_prior;
    logic signed [23:0] fb2_last;
    logic signed [23:0] fb2_prior;
  } chan_state_t;

  function automatic logic signed [15:0] sine_q15(input logic [31:0] a);
    longint f, x, x2, t, m;
    f  = longint'(a[29:14]);
    x  = a[30] ? 65536 - f : f;
    x2 = (x * x) >>> 16;
    t  = 42334 - ((4926 * x2) >>> 16);
    t  = 102944 - ((t * x2) >>> 16);
    m  = ((x * t) >>> 16) >>> 1;
    if (m > 32767) m = 32767;
    if (a[31]) m = -m;
    return 16'(m);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [31:0] a;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      a = 32'(k) << (32 - ROM_AW);
      rom[k] = sine_q15(a);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/core/two_operator_fm_voice_top.sv =====
// two_operator_fm_voice_top: two-operator fm voice with feedback, eight channels
// depends on fm2op_pkg
//
// usage: each input item carries a channel, a phase step and two operator levels;
// each item gives one output item with the channel echoed and a saturated stereo
// sample. per-channel phases and feedback taps live in one 8-entry state memory,
// read when the item is taken and written back when its result is handed off.
// one shared 34x18 multiplier and one registered sine rom port do the arithmetic,
// fourteen products in sequence, so a new item is taken only once the last one has
// been handed to the output register. the output register frees the input side:
// the next item is taken while a result waits. a stalled receiver holds the
// finished item in the last step until the output register empties.
// configuration writes land at once and are meant for idle periods only.
// reset (rst_n low, synchronous) clears phases and feedback to zero, sets volumes
// to one and pans to centre and restores register defaults.
module two_operator_fm_voice_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // channel, phase_inc, level_one, level_two, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_channel, left, right, zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import fm2op_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001, S_LOAD = 18'h00002, S_OP1  = 18'h00004, S_A2   = 18'h00008,
    S_OP2  = 18'h00010, S_B1   = 18'h00020, S_B2   = 18'h00040, S_I1   = 18'h00080,
    S_I2   = 18'h00100, S_G1A  = 18'h00200, S_G1B  = 18'h00400, S_G2A  = 18'h00800,
    S_G2B  = 18'h01000, S_L1   = 18'h02000, S_L2   = 18'h04000, S_R1   = 18'h08000,
    S_R2   = 18'h10000, S_OUT  = 18'h20000
  } fsm_t;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  fsm_t state_r, state_nxt;

  logic [31:0] ratio_r, detune_r, volume_r, pan_r;
  logic signed [15:0] i11_r, i12_r, i21_r, i22_r;
  logic [15:0] vol0_r, vol1_r, pn0_r, pn1_r;

  chan_state_t ram [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  chan_state_t mem_q_r, st_r, ld_st;
  logic rd_vld_r;

  logic [CH_W-1:0] ch_r;
  logic [31:0] inc_r;
  logic signed [15:0] lvl1_r, lvl2_r;

  logic signed [15:0] rom_q_r, op1_r, op2_r, sl1_r, sl2_r, sr1_r, sr2_r;
  logic [ROM_AW-1:0] rom_addr;
  logic [31:0] rom_phase;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod_r;
  logic signed [35:0] acc_r, acc_sum;
  logic signed [23:0] f1_r, f2_r;
  logic [31:0] p1_r, p2_r;
  logic signed [19:0] g1_r, g2_r;
  logic signed [15:0] left_r, right_r;
  logic out_tvalid_r;
  logic [39:0] out_tdata_r;

  logic signed [24:0] fsum1, fsum2;
  logic signed [32:0] s1, s2;
  logic [31:0] a_p0, a_p1;
  logic accept, hand_off;

  function automatic logic [15:0] glide(input logic [15:0] cur, input logic [15:0] tgt);
    logic signed [16:0] d;
    logic [16:0] mag, sm;
    d   = $signed({1'b0, tgt}) - $signed({1'b0, cur});
    mag = d[16] ? 17'(-d) : 17'(d);
    sm  = mag >> RAMP_SHIFT;
    if (sm == 17'd0 && d != 17'sd0) sm = 17'd1;
    return d[16] ? cur - sm[15:0] : cur + sm[15:0];
  endfunction

  function automatic logic [15:0] vol_tgt(input logic [15:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  function automatic logic [15:0] pan_tgt(input logic signed [15:0] p);
    logic signed [15:0] c;
    c = p;
    if (p < -16'sd16384) c = -16'sd16384;
    if (p > 16'sd16384) c = 16'sd16384;
    return 16'(c + 16'sd16384);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign hand_off  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign ld_st = rd_vld_r ? mem_q_r : '0;
  assign fsum1 = 25'(ld_st.fb1_last) + 25'(ld_st.fb1_prior);
  assign fsum2 = 25'(st_r.fb2_last) + 25'(st_r.fb2_prior);
  assign s1 = $signed({inc_r[31], inc_r}) +
              $signed({{9{detune_r[15]}}, detune_r[15:0], 8'b0});
  assign s2 = $signed({inc_r[31], inc_r}) +
              $signed({{9{detune_r[31]}}, detune_r[31:16], 8'b0});
  assign a_p0 = {1'b0, pn0_r, 15'b0};
  assign a_p1 = {1'b0, pn1_r, 15'b0};
  assign acc_sum = acc_r + prod_r[35:0];

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    rom_phase = '0;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_LOAD;
      S_LOAD: begin
        rom_phase = ld_st.phase1 + {fsum1[18:0], 13'b0};
        state_nxt = S_OP1;
      end
      S_OP1: begin
        mul_a = 34'(rom_q_r); mul_b = 18'(i12_r); state_nxt = S_A2;
      end
      S_A2: begin
        rom_phase = st_r.phase2 + {fsum2[18:0], 13'b0} + {prod_r[26:0], 5'b0};
        mul_a = 34'(op1_r); mul_b = 18'(i11_r); state_nxt = S_OP2;
      end
      S_OP2: begin
        mul_a = 34'(rom_q_r); mul_b = 18'(i21_r); state_nxt = S_B1;
      end
      S_B1: begin
        rom_phase = a_p0 + 32'h4000_0000;
        mul_a = 34'(op2_r); mul_b = 18'(i22_r); state_nxt = S_B2;
      end
      S_B2: begin
        rom_phase = a_p1 + 32'h4000_0000;
        mul_a = 34'(s1); mul_b = {2'b0, ratio_r[15:0]}; state_nxt = S_I1;
      end
      S_I1: begin
        rom_phase = a_p0;
        mul_a = 34'(s2); mul_b = {2'b0, ratio_r[31:16]}; state_nxt = S_I2;
      end
      S_I2: begin
        rom_phase = a_p1;
        mul_a = 34'(op1_r); mul_b = {2'b0, vol0_r}; state_nxt = S_G1A;
      end
      S_G1A: begin
        mul_a = 34'($signed(prod_r[33:15])); mul_b = 18'(lvl1_r); state_nxt = S_G1B;
      end
      S_G1B: begin
        mul_a = 34'(op2_r); mul_b = {2'b0, vol1_r}; state_nxt = S_G2A;
      end
      S_G2A: begin
        mul_a = 34'($signed(prod_r[33:15])); mul_b = 18'(lvl2_r); state_nxt = S_G2B;
      end
      S_G2B: begin
        mul_a = 34'(g1_r); mul_b = 18'(sl1_r); state_nxt = S_L1;
      end
      S_L1: begin
        mul_a = 34'(g2_r); mul_b = 18'(sl2_r); state_nxt = S_L2;
      end
      S_L2: begin
        mul_a = 34'(g1_r); mul_b = 18'(sr1_r); state_nxt = S_R1;
      end
      S_R1: begin
        mul_a = 34'(g2_r); mul_b = 18'(sr2_r); state_nxt = S_R2;
      end
      S_R2: state_nxt = S_OUT;
      S_OUT: if (hand_off) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    rom_addr = rom_phase[31:32-ROM_AW];
  end

  // control, configuration and smoothers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      vld_r        <= '0;
      ratio_r      <= RATIO_RST;
      detune_r     <= '0;
      i11_r        <= '0;
      i12_r        <= '0;
      i21_r        <= '0;
      i22_r        <= '0;
      volume_r     <= VOLUME_RST;
      pan_r        <= '0;
      vol0_r       <= UNITY;
      vol1_r       <= UNITY;
      pn0_r        <= CENTRE;
      pn1_r        <= CENTRE;
    end else begin
      state_r <= state_nxt;
      if (hand_off) begin
        out_tvalid_r <= 1'b1;
        vld_r[ch_r]  <= 1'b1;
        vol0_r <= glide(vol0_r, vol_tgt(volume_r[15:0]));
        vol1_r <= glide(vol1_r, vol_tgt(volume_r[31:16]));
        pn0_r  <= glide(pn0_r, pan_tgt(pan_r[15:0]));
        pn1_r  <= glide(pn1_r, pan_tgt(pan_r[31:16]));
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_RATIO:  ratio_r  <= cfg_data;
          REG_DETUNE: detune_r <= cfg_data;
          REG_I11:    i11_r    <= cfg_data[15:0];
          REG_I12:    i12_r    <= cfg_data[15:0];
          REG_I21:    i21_r    <= cfg_data[15:0];
          REG_I22:    i22_r    <= cfg_data[15:0];
          REG_VOLUME: volume_r <= cfg_data;
          REG_PAN:    pan_r    <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // state memory, rom and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q_r  <= ram[in_tdata[CH_W-1:0]];
      rd_vld_r <= vld_r[in_tdata[CH_W-1:0]];
      ch_r     <= in_tdata[CH_W-1:0];
      inc_r    <= in_tdata[34:3];
      lvl1_r   <= in_tdata[50:35];
      lvl2_r   <= in_tdata[66:51];
    end
    if (hand_off) begin
      ram[ch_r]   <= '{phase1: p1_r, phase2: p2_r,
                       fb1_last: f1_r, fb1_prior: st_r.fb1_last,
                       fb2_last: f2_r, fb2_prior: st_r.fb2_last};
      out_tdata_r <= {5'b0, right_r, left_r, ch_r};
    end
    rom_q_r <= SINE_ROM[rom_addr];
    prod_r  <= mul_a * mul_b;
    case (state_r)
      S_LOAD: st_r  <= ld_st;
      S_OP1:  op1_r <= rom_q_r;
      S_OP2: begin
        op2_r <= rom_q_r;
        acc_r <= prod_r[35:0];
      end
      S_B1:  f1_r  <= acc_sum[32:9];
      S_B2: begin
        f2_r  <= prod_r[32:9];
        sl1_r <= rom_q_r;
      end
      S_I1: begin
        p1_r  <= st_r.phase1 + prod_r[39:8];
        sl2_r <= rom_q_r;
      end
      S_I2: begin
        p2_r  <= st_r.phase2 + prod_r[39:8];
        sr1_r <= rom_q_r;
      end
      S_G1A: sr2_r <= rom_q_r;
      S_G1B: g1_r  <= prod_r[31:12];
      S_G2B: g2_r  <= prod_r[31:12];
      S_L1:  acc_r <= prod_r[35:0];
      S_L2:  left_r <= sat16(acc_sum[35:15]);
      S_R1:  acc_r <= prod_r[35:0];
      S_R2:  right_r <= sat16(acc_sum[35:15]);
      default: ;
    endcase
  end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for two_operator_fm_voice_top, streaming in and out
// depends on fm2op_pkg and the rtl top; predicts each stereo sample in-bench
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fm2op_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  two_operator_fm_voice_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  typedef struct {
    logic [2:0]         ch;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } mix_t;

  // predictor state
  logic [31:0] regs_q [8];
  logic [31:0] ph1 [8], ph2 [8];
  longint      fb1l [8], fb1p [8], fb2l [8], fb2p [8];
  longint      vol_s [2], pan_s [2];
  mix_t        mix_q [$];
  int          errors = 0;
  int          send_idle = 0, recv_idle = 0;
  longint      cycles = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sext16(logic [31:0] v);
    return longint'(signed'(v[15:0]));
  endfunction

  function automatic longint wave(logic [31:0] a);
    longint f, x, x2, t, m;
    f  = longint'(a[29:14]);
    x  = a[30] ? 65536 - f : f;
    x2 = (x * x) >>> 16;
    t  = 42334 - ((4926 * x2) >>> 16);
    t  = 102944 - ((t * x2) >>> 16);
    m  = ((x * t) >>> 16) >>> 1;
    if (m > 32767) m = 32767;
    return a[31] ? -m : m;
  endfunction

  function automatic longint table_sine(logic [31:0] p);
    logic [31:0] a;
    a = p & ~(32'hFFFF_FFFF >> ROM_AW);
    return wave(a);
  endfunction

  function automatic longint wrap24(longint v);
    logic [23:0] x;
    x = v[23:0];
    return longint'(signed'(x));
  endfunction

  function automatic longint glide(longint cur, longint tgt);
    longint d, s;
    d = tgt - cur;
    s = d >= 0 ? (d >>> RAMP_SHIFT) : -((-d) >>> RAMP_SHIFT);
    if (s == 0 && d != 0) s = d > 0 ? 1 : -1;
    return cur + s;
  endfunction

  function automatic logic [31:0] phase_step(logic [31:0] pinc, int sel);
    longint base, det, ratio, s, p;
    base  = longint'(signed'(pinc));
    det   = sext16(regs_q[REG_DETUNE] >> (sel * 16));
    ratio = longint'(regs_q[REG_RATIO][sel*16 +: 16]);
    s = base + det * 256;
    p = s * ratio;
    return p[39:8];
  endfunction

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic predictor_reset();
    for (int c = 0; c < 8; c++) begin
      ph1[c] = 0; ph2[c] = 0; fb1l[c] = 0; fb1p[c] = 0; fb2l[c] = 0; fb2p[c] = 0;
      regs_q[c] = 0;
    end
    regs_q[REG_RATIO] = RATIO_RST;
    regs_q[REG_VOLUME] = VOLUME_RST;
    vol_s[0] = 32768; vol_s[1] = 32768;
    pan_s[0] = 16384; pan_s[1] = 16384;
  endtask

  function automatic mix_t predict_mix(logic [2:0] ch, logic [31:0] pinc,
                                       logic [15:0] lv1, logic [15:0] lv2);
    mix_t r;
    longint i11, i12, i21, i22, op1, op2, bus1, bus2, g1, g2, l, rt, tv, tp;
    logic [31:0] m1, m2, a1, a2, sum;
    logic [63:0] prod;
    r.ch = ch; r.left = 0; r.right = 0;
    if (ch >= CHANNELS) return r;
    i11 = sext16(regs_q[REG_I11]); i12 = sext16(regs_q[REG_I12]);
    i21 = sext16(regs_q[REG_I21]); i22 = sext16(regs_q[REG_I22]);
    sum = 32'(fb1l[ch] + fb1p[ch]);
    m1 = sum << 13;
    op1 = table_sine(ph1[ch] + m1);
    sum = 32'(fb2l[ch] + fb2p[ch]);
    m2 = sum << 13;
    prod = 64'(op1 * i12);
    m2 += 32'(prod << 5);
    op2 = table_sine(ph2[ch] + m2);
    bus1 = fshift(op1 * i11 + op2 * i21, 9);
    bus2 = fshift(op2 * i22, 9);
    ph1[ch] += phase_step(pinc, 0);
    ph2[ch] += phase_step(pinc, 1);
    g1 = fshift(fshift(op1 * vol_s[0], 15) * longint'(signed'(lv1)), 12);
    g2 = fshift(fshift(op2 * vol_s[1], 15) * longint'(signed'(lv2)), 12);
    a1 = 32'(pan_s[0]) << 15;
    a2 = 32'(pan_s[1]) << 15;
    l  = fshift(g1 * table_sine(a1 + 32'h4000_0000) + g2 * table_sine(a2 + 32'h4000_0000), 15);
    rt = fshift(g1 * table_sine(a1) + g2 * table_sine(a2), 15);
    r.left = 16'(clamp16(l));
    r.right = 16'(clamp16(rt));
    fb1p[ch] = fb1l[ch]; fb1l[ch] = wrap24(bus1);
    fb2p[ch] = fb2l[ch]; fb2l[ch] = wrap24(bus2);
    for (int k = 0; k < 2; k++) begin
      tv = longint'(regs_q[REG_VOLUME][k*16 +: 16]);
      if (tv > 32768) tv = 32768;
      tp = sext16(regs_q[REG_PAN] >> (k * 16));
      if (tp < -16384) tp = -16384;
      if (tp > 16384) tp = 16384;
      vol_s[k] = glide(vol_s[k], tv);
      pan_s[k] = glide(pan_s[k], tp + 16384);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result checking
  always @(posedge clk) begin
    mix_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (mix_q.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[2:0], -1);
      end else begin
        e = mix_q.pop_front();
        if (out_tdata[2:0] !== e.ch) report_mismatch("channel", out_tdata[2:0], e.ch);
        if (out_tdata[18:3] !== e.left)
          report_mismatch("left", signed'(out_tdata[18:3]), e.left);
        if (out_tdata[34:19] !== e.right)
          report_mismatch("right", signed'(out_tdata[34:19]), e.right);
      end
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    regs_q[idx] = (idx >= REG_I11 && idx <= REG_I22) ? {16'h0, val[15:0]} : val;
  endtask

  task automatic drain();
    while (mix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_item(logic [2:0] ch, logic [31:0] pinc, logic [15:0] lv1,
                           logic [15:0] lv2);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_tdata <= {5'h0, lv2, lv1, pinc, ch};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mix_q.push_back(predict_mix(ch, pinc, lv1, lv2));
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  typedef struct {
    logic [2:0]  ch;
    logic [31:0] pinc;
    logic [15:0] lv1, lv2;
  } row_t;

  row_t rows [] = '{
    '{3'd0, 32'h0000_0000, 16'h1000, 16'h1000},
    '{3'd7, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF},
    '{3'd7, 32'h8000_0000, 16'h8000, 16'h8000},
    '{3'd1, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF},
    '{3'd1, 32'h0100_0000, 16'h7FFF, 16'h8000},
    '{3'd2, 32'h4000_0000, 16'h1000, 16'h0000},
    '{3'd2, 32'h4000_0000, 16'h0000, 16'h1000},
    '{3'd3, 32'h0123_4567, 16'h8001, 16'h7FFF},
    '{3'd0, 32'h0080_0000, 16'h1000, 16'h1000},
    '{3'd0, 32'h0080_0000, 16'h1000, 16'h1000}
  };

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++)
      send_item(3'($urandom), $urandom_range(3) == 0 ? $urandom : $urandom >> $urandom_range(31),
                16'($urandom), $urandom_range(3) == 0 ? 16'h7FFF : 16'($urandom));
  endtask

  task automatic random_regs();
    logic [31:0] v;
    for (int r = 0; r < 8; r++) begin
      v = $urandom;
      if (r >= REG_I11 && r <= REG_I22 && $urandom_range(1)) v = v >>> $urandom_range(2, 12);
      write_reg(3'(r), v);
    end
  endtask

  initial begin
    predictor_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    send_idle = 16; recv_idle = 60;
    foreach (rows[i]) send_item(rows[i].ch, rows[i].pinc, rows[i].lv1, rows[i].lv2);
    drain();
    // extreme settings: max ratios, feedback and cross indices at limits, hard pans
    write_reg(REG_RATIO, 32'hFFFF_FFFF);
    write_reg(REG_DETUNE, 32'h8000_7FFF);
    write_reg(REG_I11, 32'h0000_7FFF);
    write_reg(REG_I12, 32'h0000_8000);
    write_reg(REG_I21, 32'h0000_7FFF);
    write_reg(REG_I22, 32'h0000_8000);
    write_reg(REG_VOLUME, 32'hFFFF_0000);
    write_reg(REG_PAN, 32'h8000_7FFF);
    random_burst(12);
    drain();
    write_reg(REG_RATIO, 32'h0000_0000);
    write_reg(REG_VOLUME, 32'h0000_FFFF);
    write_reg(REG_PAN, 32'h4000_C000);
    random_burst(3);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 60; recv_idle = 16; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      random_regs();
      random_burst(200);
      drain();
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fm2op_pkg.sv
rtl/core/two_operator_fm_voice_top.sv
dv/tb_top.sv
